### design/vref_pkg.sv
package vref_pkg;

   localparam int FRAC_BITS = 14;
   localparam int IOR_W = 15;
   localparam int ETA_W = FRAC_BITS + 13;
   localparam int DIV_STEPS = FRAC_BITS + 13;
   localparam int K_W = 62;
   localparam int ROOT_W = K_W / 2;
   localparam int OUT_W = 16;
   localparam int OUT_MAX = 1 << FRAC_BITS;

   typedef logic signed [15:0] in_vec_type;
   typedef logic signed [16:0] nrm_vec_type;

   // Values that ride alongside the arithmetic, including through the square root.
   typedef struct packed {
      logic                   tir;
      logic [31:0]            ec;
      logic [ETA_W-1:0]       eta;
      in_vec_type [2:0]       v;
      nrm_vec_type [2:0]      n;
   } side_type;

   // Round a signed value by FRAC_BITS, half away from zero.
   function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] p);
      logic [63:0] m;
      logic [63:0] r;
      begin
         m = p[63] ? 64'(-p) : 64'(p);
         r = (m + 64'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
         return p[63] ? -$signed(r) : $signed(r);
      end
   endfunction

endpackage

### design/vector_refraction_unit.sv
// Channel   Ports                                     Handshake
// request   req_incident_*, req_normal_*              taken when start && !busy
// response  rsp_refracted_*, rsp_total_reflection    rsp_valid for one cycle
// config    csr_write_enable, csr_write_data          written when enable is high
//
// A new item may be taken every cycle; items are held off while busy is high.
// Each item runs through the 31-stage square root plus ten arithmetic stages.
// After reset, and after each index write, a reciprocal divider runs
// and busy stays high until it finishes.
// The receiver cannot stall, so nothing inside ever holds.
module vector_refraction_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_incident_x,
   input  logic signed [15:0] req_incident_y,
   input  logic signed [15:0] req_incident_z,
   input  logic signed [15:0] req_normal_x,
   input  logic signed [15:0] req_normal_y,
   input  logic signed [15:0] req_normal_z,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_refracted_x,
   output logic signed [15:0] rsp_refracted_y,
   output logic signed [15:0] rsp_refracted_z,
   output logic               rsp_total_reflection,
   input  logic               csr_write_enable,
   input  logic [14:0]        csr_write_data
);

   localparam int F = vref_pkg::FRAC_BITS;
   localparam int NS = vref_pkg::ROOT_W;

   logic [vref_pkg::IOR_W-1:0] ior_ff;
   logic                       div_start_ff;
   logic                       div_busy;
   logic [vref_pkg::ETA_W-1:0] recip;
   logic                       accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         ior_ff       <= vref_pkg::IOR_W'(6144);
         div_start_ff <= 1'b1;
      end else begin
         if (csr_write_enable) begin
            ior_ff <= csr_write_data;
         end
         div_start_ff <= csr_write_enable;
      end
   end

   vref_recip u_recip (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .den      (ior_ff),
      .busy     (div_busy),
      .quotient (recip)
   );

   assign busy   = csr_write_enable | div_start_ff | div_busy;
   assign accept = start & ~busy;

   // Stage A: capture the item.
   logic                   va_ff;
   vref_pkg::in_vec_type   v_a_ff [0:2];
   vref_pkg::in_vec_type   n_a_ff [0:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else begin
         va_ff <= accept;
      end
      v_a_ff[0] <= req_incident_x;
      v_a_ff[1] <= req_incident_y;
      v_a_ff[2] <= req_incident_z;
      n_a_ff[0] <= req_normal_x;
      n_a_ff[1] <= req_normal_y;
      n_a_ff[2] <= req_normal_z;
   end

   // Stage B: dot product.
   logic                 vb_ff;
   logic signed [33:0]   d_in, d_ff;
   vref_pkg::in_vec_type v_b_ff [0:2];
   vref_pkg::in_vec_type n_b_ff [0:2];

   assign d_in = 34'(v_a_ff[0] * n_a_ff[0]) + 34'(v_a_ff[1] * n_a_ff[1])
               + 34'(v_a_ff[2] * n_a_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else begin
         vb_ff <= va_ff;
      end
      d_ff <= d_in;
      for (int i = 0; i < 3; i++) begin
         v_b_ff[i] <= v_a_ff[i];
         n_b_ff[i] <= n_a_ff[i];
      end
   end

   // Stage C: cosine, side of the surface and index ratio.
   logic                vc_ff;
   logic [33:0]         dmag;
   logic [18:0]         cos_in, cos_ff;
   vref_pkg::side_type  sc_in, sc_ff;

   assign dmag   = d_ff[33] ? 34'(-d_ff) : 34'(d_ff);
   assign cos_in = 19'((dmag + 34'(1 << (F - 1))) >> F);

   always_comb begin
      sc_in     = '0;
      sc_in.eta = d_ff[33] ? vref_pkg::ETA_W'({ior_ff, 2'b00}) : recip;
      for (int i = 0; i < 3; i++) begin
         sc_in.v[i] = v_b_ff[i];
         sc_in.n[i] = d_ff[33] ? -17'(n_b_ff[i]) : 17'(n_b_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else begin
         vc_ff <= vb_ff;
      end
      cos_ff <= cos_in;
      sc_ff  <= sc_in;
   end

   // Stage D: eta squared, cosine squared and eta times cosine.
   logic               vd_ff;
   logic [53:0]        ee;
   logic [37:0]        cc2;
   logic [45:0]        ecp;
   logic [39:0]        eta2_in, eta2_ff;
   logic [21:0]        cc_in, cc_ff;
   vref_pkg::side_type sd_in, sd_ff;

   assign ee      = 54'(sc_ff.eta) * 54'(sc_ff.eta);
   assign cc2     = 38'(cos_ff) * 38'(cos_ff);
   assign ecp     = 46'(sc_ff.eta) * 46'(cos_ff);
   assign eta2_in = 40'((ee + 54'(1 << (F - 1))) >> F);
   assign cc_in   = 22'((cc2 + 38'(1 << (F - 1))) >> F);

   always_comb begin
      sd_in    = sc_ff;
      sd_in.ec = 32'((ecp + 46'(1 << (F - 1))) >> F);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= 1'b0;
      end else begin
         vd_ff <= vc_ff;
      end
      eta2_ff <= eta2_in;
      cc_ff   <= cc_in;
      sd_ff   <= sd_in;
   end

   // Stage E: one minus cosine squared.
   logic               ve_ff;
   logic signed [23:0] omc_ff;
   logic [39:0]        eta2_e_ff;
   vref_pkg::side_type se_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ve_ff <= 1'b0;
      end else begin
         ve_ff <= vd_ff;
      end
      omc_ff    <= 24'(1 << F) - 24'(cc_ff);
      eta2_e_ff <= eta2_ff;
      se_ff     <= sd_ff;
   end

   // Stage F: eta squared times (1 - cos^2) as two partial products.
   logic               vf_ff;
   logic signed [44:0] plo_ff, phi_ff;
   vref_pkg::side_type sf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vf_ff <= 1'b0;
      end else begin
         vf_ff <= ve_ff;
      end
      plo_ff <= 45'($signed({1'b0, eta2_e_ff[19:0]}) * omc_ff);
      phi_ff <= 45'($signed({1'b0, eta2_e_ff[39:20]}) * omc_ff);
      sf_ff  <= se_ff;
   end

   // Stage G: radicand and total internal reflection test.
   logic               vg_ff;
   logic signed [65:0] prod;
   logic signed [65:0] k_full;
   logic [vref_pkg::K_W-1:0] k_ff;
   vref_pkg::side_type sg_in, sg_ff;

   assign prod   = (66'(phi_ff) <<< 20) + 66'(plo_ff);
   assign k_full = 66'(1 << (2 * F)) - prod;

   always_comb begin
      sg_in     = sf_ff;
      sg_in.tir = k_full[65];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vg_ff <= 1'b0;
      end else begin
         vg_ff <= vf_ff;
      end
      k_ff  <= k_full[65] ? '0 : k_full[vref_pkg::K_W-1:0];
      sg_ff <= sg_in;
   end

   // Square root, with the other values delayed to match.
   logic                   vs;
   logic [NS-1:0]          root;
   vref_pkg::side_type     side_ff [0:NS-1];

   vref_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vg_ff),
      .radicand  (k_ff),
      .out_valid (vs),
      .root      (root)
   );

   always_ff @(posedge clock) begin
      side_ff[0] <= sg_ff;
      for (int s = 1; s < NS; s++) begin
         side_ff[s] <= side_ff[s-1];
      end
   end

   // Stage H: t = eta*cos - sqrt(k).
   logic               vh_ff;
   logic signed [32:0] t_ff;
   vref_pkg::side_type sh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vh_ff <= 1'b0;
      end else begin
         vh_ff <= vs;
      end
      t_ff  <= $signed(33'(side_ff[NS-1].ec)) - $signed(33'(root));
      sh_ff <= side_ff[NS-1];
   end

   // Stage I: component products.
   logic               vi_ff;
   logic               tir_i_ff;
   logic signed [35:0] pv_ff [0:2];
   logic signed [35:0] pn_ff [0:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         vi_ff <= 1'b0;
      end else begin
         vi_ff <= vh_ff;
      end
      tir_i_ff <= sh_ff.tir;
      for (int i = 0; i < 3; i++) begin
         pv_ff[i] <= 36'(vref_pkg::rnd_shift(64'($signed({1'b0, sh_ff.eta})
                     * -$signed(17'($signed(sh_ff.v[i]))))));
         pn_ff[i] <= 36'(vref_pkg::rnd_shift(64'(t_ff * $signed(sh_ff.n[i]))));
      end
   end

   // Stage J: sum, clamp and present.
   logic signed [36:0] r_sum [0:2];
   logic signed [15:0] r_clamp [0:2];
   logic signed [15:0] out_ff [0:2];
   logic               out_vld_ff;
   logic               out_tir_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         r_sum[i] = 37'(pv_ff[i]) + 37'(pn_ff[i]);
         if (r_sum[i] > 37'(vref_pkg::OUT_MAX)) begin
            r_clamp[i] = 16'(vref_pkg::OUT_MAX);
         end else if (r_sum[i] < -37'(vref_pkg::OUT_MAX)) begin
            r_clamp[i] = -16'(vref_pkg::OUT_MAX);
         end else begin
            r_clamp[i] = r_sum[i][15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= vi_ff;
      end
      out_tir_ff <= tir_i_ff;
      for (int i = 0; i < 3; i++) begin
         out_ff[i] <= tir_i_ff ? 16'sd0 : r_clamp[i];
      end
   end

   assign rsp_valid            = out_vld_ff;
   assign rsp_total_reflection = out_tir_ff;
   assign rsp_refracted_x      = out_ff[0];
   assign rsp_refracted_y      = out_ff[1];
   assign rsp_refracted_z      = out_ff[2];

   // On total internal reflection the vector must be zero.
   a_tir_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_total_reflection |->
         rsp_refracted_x == 16'sd0 && rsp_refracted_y == 16'sd0 && rsp_refracted_z == 16'sd0)
      else $error("refraction: nonzero vector on total reflection");

   // Every component stays within plus or minus one.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_refracted_x <= 16'sd16384 && rsp_refracted_x >= -16'sd16384
         && rsp_refracted_y <= 16'sd16384 && rsp_refracted_y >= -16'sd16384
         && rsp_refracted_z <= 16'sd16384 && rsp_refracted_z >= -16'sd16384)
      else $error("refraction: component out of range");

   // An index write keeps items out until the reciprocal is rebuilt.
   a_cfg_busy: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> busy && div_start_ff)
      else $error("refraction: item path open after index write");

endmodule

### design/vref_recip.sv
module vref_recip (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [vref_pkg::IOR_W-1:0]  den,
   output logic                        busy,
   output logic [vref_pkg::ETA_W-1:0]  quotient
);

   localparam int CNT_W = $clog2(vref_pkg::DIV_STEPS + 1);

   logic [vref_pkg::IOR_W-1:0] den_eff;
   logic [vref_pkg::ETA_W-1:0] num_ff, num_in;
   logic [vref_pkg::IOR_W-1:0] rem_ff, rem_in;
   logic [vref_pkg::IOR_W:0]   rem_sh;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       run_ff, run_in;

   // A zero index divides as if it were one LSB.
   assign den_eff = (den == '0) ? vref_pkg::IOR_W'(1) : den;
   assign rem_sh  = {rem_ff, num_ff[vref_pkg::ETA_W-1]};

   always_comb begin
      num_in = num_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      if (start) begin
         // The numerator carries half the divisor so the quotient rounds.
         num_in = vref_pkg::ETA_W'(1 << (vref_pkg::FRAC_BITS + 12))
                  + vref_pkg::ETA_W'(den_eff >> 1);
         rem_in = '0;
         cnt_in = CNT_W'(vref_pkg::DIV_STEPS);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (rem_sh >= {1'b0, den_eff}) begin
            rem_in = vref_pkg::IOR_W'(rem_sh - {1'b0, den_eff});
            num_in = {num_ff[vref_pkg::ETA_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[vref_pkg::IOR_W-1:0];
            num_in = {num_ff[vref_pkg::ETA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         run_in = (cnt_ff != CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
   end

   assign busy     = run_ff;
   assign quotient = num_ff;

endmodule

### design/vref_sqrt.sv
module vref_sqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [vref_pkg::K_W-1:0]     radicand,
   output logic                         out_valid,
   output logic [vref_pkg::ROOT_W-1:0]  root
);

   localparam int N = vref_pkg::ROOT_W;

   logic [vref_pkg::K_W-1:0] x_ff    [0:N-1];
   logic [32:0]              rem_ff  [0:N-1];
   logic [32:0]              rem_in  [0:N-1];
   logic [N-1:0]             root_ff [0:N-1];
   logic [N-1:0]             root_in [0:N-1];
   logic [N-1:0]             vld_ff;

   // One result bit is settled in each stage.
   always_comb begin
      logic [vref_pkg::K_W-1:0] x_prev;
      logic [32:0]              rem_prev;
      logic [N-1:0]             root_prev;
      logic [34:0]              rem_sh;
      logic [34:0]              trial;
      for (int s = 0; s < N; s++) begin
         if (s == 0) begin
            x_prev    = radicand;
            rem_prev  = '0;
            root_prev = '0;
         end else begin
            x_prev    = x_ff[s-1];
            rem_prev  = rem_ff[s-1];
            root_prev = root_ff[s-1];
         end
         rem_sh = {rem_prev, x_prev[vref_pkg::K_W-1 -: 2]};
         trial  = 35'({root_prev, 2'b01});
         if (rem_sh >= trial) begin
            rem_in[s]  = 33'(rem_sh - trial);
            root_in[s] = {root_prev[N-2:0], 1'b1};
         end else begin
            rem_in[s]  = rem_sh[32:0];
            root_in[s] = {root_prev[N-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[N-2:0], in_valid};
      end
      x_ff[0] <= {radicand[vref_pkg::K_W-3:0], 2'b00};
      for (int s = 1; s < N; s++) begin
         x_ff[s] <= {x_ff[s-1][vref_pkg::K_W-3:0], 2'b00};
      end
      for (int s = 0; s < N; s++) begin
         rem_ff[s]  <= rem_in[s];
         root_ff[s] <= root_in[s];
      end
   end

   assign out_valid = vld_ff[N-1];
   assign root      = root_ff[N-1];

endmodule
